// ----- rtl/dbst_pkg.sv -----
// Shared types and constants for the debug break and step trigger.
// Holds action and step codes, the breakpoint key type and the table interface structs.
// No dependencies.
package dbst_pkg;

    localparam int BP_SLOTS = 16;

    typedef logic [23:0] bp_key_t;

    typedef enum logic [2:0] {
        ACT_LINE      = 3'd0,
        ACT_ADD       = 3'd1,
        ACT_REMOVE    = 3'd2,
        ACT_REQUEST   = 3'd3,
        ACT_RESUME    = 3'd4,
        ACT_STEP_INTO = 3'd5,
        ACT_STEP_OVER = 3'd6,
        ACT_STEP_OUT  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_INTO = 2'd1,
        STEP_OVER = 2'd2,
        STEP_OUT  = 2'd3
    } step_kind_t;

    localparam logic [1:0] REASON_BP      = 2'd0;
    localparam logic [1:0] REASON_REQUEST = 2'd1;
    localparam logic [1:0] REASON_STEP    = 2'd2;

    typedef struct packed {
        logic add;
        logic remove;
    } bp_cmd_t;

    typedef struct packed {
        logic hit;
        logic full;
    } bp_status_t;

endpackage

// ----- rtl/dbst_bp_table.sv -----
// Breakpoint table: BP_SLOTS (script, line) keys with valid bits.
// Parallel match, lowest-free-slot insertion, removal of the matching slot.
// Depends on dbst_pkg.
module dbst_bp_table
    import dbst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bp_key_t    key,
    input  bp_cmd_t    cmd,
    output bp_status_t status
);

    logic [BP_SLOTS-1:0] valid_reg;
    logic [BP_SLOTS-1:0] valid_next;
    logic [BP_SLOTS-1:0] match;
    logic [BP_SLOTS-1:0] free;
    logic [BP_SLOTS-1:0] free_first;
    logic                insert;
    bp_key_t             entry_reg [BP_SLOTS];

    always_comb
    begin
        for (int i = 0; i < BP_SLOTS; i++)
        begin
            match[i] = valid_reg[i] && (entry_reg[i] == key);
        end
    end

    assign free       = ~valid_reg;
    assign free_first = free & (~free + BP_SLOTS'(1));

    assign status.hit  = |match;
    assign status.full = &valid_reg;

    assign insert = cmd.add && !status.hit;

    always_comb
    begin
        valid_next = valid_reg;
        if (insert)
        begin
            valid_next = valid_reg | free_first;
        end
        else if (cmd.remove)
        begin
            valid_next = valid_reg & ~match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BP_SLOTS; i++)
        begin
            if (insert && free_first[i])
            begin
                entry_reg[i] <= key;
            end
        end
    end

endmodule

// ----- rtl/debug_break_and_step_trigger.sv -----
// Debug trigger unit: breakpoint table, pause request and step detection.
// Flow: a transaction taken into the input register gives its result strobe (done) from the result register.
// Throughput: one transaction per cycle; busy stays low, set by the single compute stage
// between the input register and the result register, which also updates all state.
// Reset (rst_n, asynchronous): table empty, not paused, no step armed, no location seen.
// Depends on dbst_pkg and dbst_bp_table.
module debug_break_and_step_trigger
    import dbst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [15:0] code_token,
    input  logic [7:0]  script_id,
    input  logic [15:0] line_number,
    input  logic [9:0]  call_depth,
    output logic        done,
    output logic        pause_now,
    output logic [1:0]  pause_reason,
    output logic        is_paused,
    output logic        table_full
);

    logic        in_valid_reg;
    action_t     in_action_reg;
    logic [15:0] in_token_reg;
    logic [7:0]  in_script_reg;
    logic [15:0] in_line_reg;
    logic [9:0]  in_depth_reg;

    logic        pending_reg,   pending_next;
    logic        paused_reg,    paused_next;
    step_kind_t  step_kind_reg, step_kind_next;
    logic [9:0]  armed_depth_reg, armed_depth_next;
    logic [15:0] armed_line_reg,  armed_line_next;
    logic [9:0]  held_depth_reg,  held_depth_next;
    logic [15:0] held_line_reg,   held_line_next;
    logic        last_valid_reg,  last_valid_next;
    logic [15:0] last_token_reg,  last_token_next;
    logic [15:0] last_line_reg,   last_line_next;
    logic [9:0]  last_depth_reg,  last_depth_next;

    logic        done_reg;
    logic        pause_now_reg,  pause_now_next;
    logic [1:0]  reason_reg,     reason_next;
    logic        full_reg,       full_next;

    logic        accept;
    logic        repeat_loc;
    logic        evaluate;
    logic        step_hit;
    logic        do_pause;
    bp_cmd_t     bp_cmd;
    bp_status_t  bp_status;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    dbst_bp_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    ({in_script_reg, in_line_reg}),
        .cmd    (bp_cmd),
        .status (bp_status)
    );

    assign bp_cmd.add    = in_valid_reg && (in_action_reg == ACT_ADD);
    assign bp_cmd.remove = in_valid_reg && (in_action_reg == ACT_REMOVE);

    assign repeat_loc = last_valid_reg && (last_token_reg == in_token_reg)
                        && (last_line_reg == in_line_reg) && (last_depth_reg == in_depth_reg);
    assign evaluate   = in_valid_reg && (in_action_reg == ACT_LINE) && !paused_reg && !repeat_loc;

    always_comb
    begin
        case (step_kind_reg)
            STEP_INTO: step_hit = (in_depth_reg != armed_depth_reg)
                                  || (in_line_reg != armed_line_reg);
            STEP_OVER: step_hit = (in_depth_reg < armed_depth_reg)
                                  || ((in_depth_reg == armed_depth_reg)
                                      && (in_line_reg != armed_line_reg));
            STEP_OUT:  step_hit = in_depth_reg < armed_depth_reg;
            default:   step_hit = 1'b0;
        endcase
    end

    assign do_pause = evaluate && (pending_reg || bp_status.hit || step_hit);

    always_comb
    begin
        pending_next     = pending_reg;
        paused_next      = paused_reg;
        step_kind_next   = step_kind_reg;
        armed_depth_next = armed_depth_reg;
        armed_line_next  = armed_line_reg;
        held_depth_next  = held_depth_reg;
        held_line_next   = held_line_reg;
        last_valid_next  = last_valid_reg;
        last_token_next  = last_token_reg;
        last_line_next   = last_line_reg;
        last_depth_next  = last_depth_reg;
        pause_now_next   = 1'b0;
        reason_next      = REASON_BP;
        full_next        = 1'b0;

        if (in_valid_reg)
        begin
            unique case (in_action_reg)
                ACT_LINE:
                begin
                    if (evaluate)
                    begin
                        last_valid_next = 1'b1;
                        last_token_next = in_token_reg;
                        last_line_next  = in_line_reg;
                        last_depth_next = in_depth_reg;
                    end
                    if (do_pause)
                    begin
                        pause_now_next  = 1'b1;
                        reason_next     = bp_status.hit ? REASON_BP
                                        : (pending_reg ? REASON_REQUEST : REASON_STEP);
                        pending_next    = 1'b0;
                        step_kind_next  = STEP_NONE;
                        paused_next     = 1'b1;
                        held_depth_next = in_depth_reg;
                        held_line_next  = in_line_reg;
                    end
                end
                ACT_ADD:
                begin
                    full_next = !bp_status.hit && bp_status.full;
                end
                ACT_REMOVE:
                begin
                end
                ACT_REQUEST:
                begin
                    pending_next = 1'b1;
                end
                ACT_RESUME:
                begin
                    step_kind_next = STEP_NONE;
                    paused_next    = 1'b0;
                end
                ACT_STEP_INTO, ACT_STEP_OVER, ACT_STEP_OUT:
                begin
                    unique case (in_action_reg)
                        ACT_STEP_INTO: step_kind_next = STEP_INTO;
                        ACT_STEP_OVER: step_kind_next = STEP_OVER;
                        default:       step_kind_next = STEP_OUT;
                    endcase
                    armed_depth_next = held_depth_reg;
                    armed_line_next  = held_line_reg;
                    paused_next      = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_action_reg   <= ACT_LINE;
            in_token_reg    <= '0;
            in_script_reg   <= '0;
            in_line_reg     <= '0;
            in_depth_reg    <= '0;
            pending_reg     <= 1'b0;
            paused_reg      <= 1'b0;
            step_kind_reg   <= STEP_NONE;
            armed_depth_reg <= '0;
            armed_line_reg  <= '0;
            held_depth_reg  <= '0;
            held_line_reg   <= '0;
            last_valid_reg  <= 1'b0;
            last_token_reg  <= '0;
            last_line_reg   <= '0;
            last_depth_reg  <= '0;
            done_reg        <= 1'b0;
            pause_now_reg   <= 1'b0;
            reason_reg      <= REASON_BP;
            full_reg        <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            if (accept)
            begin
                in_action_reg <= action_t'(action);
                in_token_reg  <= code_token;
                in_script_reg <= script_id;
                in_line_reg   <= line_number;
                in_depth_reg  <= call_depth;
            end
            pending_reg     <= pending_next;
            paused_reg      <= paused_next;
            step_kind_reg   <= step_kind_next;
            armed_depth_reg <= armed_depth_next;
            armed_line_reg  <= armed_line_next;
            held_depth_reg  <= held_depth_next;
            held_line_reg   <= held_line_next;
            last_valid_reg  <= last_valid_next;
            last_token_reg  <= last_token_next;
            last_line_reg   <= last_line_next;
            last_depth_reg  <= last_depth_next;
            done_reg        <= in_valid_reg;
            pause_now_reg   <= pause_now_next;
            reason_reg      <= reason_next;
            full_reg        <= full_next;
        end
    end

    assign done         = done_reg;
    assign pause_now    = pause_now_reg;
    assign pause_reason = reason_reg;
    assign is_paused    = paused_reg;
    assign table_full   = full_reg;

endmodule

// ----- rtl/dbst_checker.sv -----
// Port-level checker for debug_break_and_step_trigger, with its bind statement.
// Depends on dbst_pkg for the pause reason codes.
module dbst_checker
    import dbst_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       pause_now,
    input logic [1:0] pause_reason,
    input logic       is_paused,
    input logic       table_full
);

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy && rst_n, 2) && $past(rst_n, 1) |-> done)
    else $error("transaction not answered two cycles after acceptance");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && pause_now |-> is_paused && !table_full)
    else $error("pause reported without paused state");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && pause_now |-> (pause_reason == REASON_BP) || (pause_reason == REASON_REQUEST)
                              || (pause_reason == REASON_STEP))
    else $error("illegal pause reason");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !pause_now |-> pause_reason == REASON_BP)
    else $error("pause reason set without a pause");

endmodule

bind debug_break_and_step_trigger dbst_checker u_dbst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .pause_now    (pause_now),
    .pause_reason (pause_reason),
    .is_paused    (is_paused),
    .table_full   (table_full)
);

// ----- dv/debug_break_and_step_trigger_tb.sv -----
// Testbench for debug_break_and_step_trigger: directed and random transactions checked
// against a cycle-free predictor of the breakpoint table, pause request and step logic.
// Depends on dbst_pkg and the RTL of the trigger unit.
import dbst_pkg::*;

class pause_predictor;
    typedef struct packed {
        logic       pnow;
        logic [1:0] reason;
        logic       paused;
        logic       full;
    } outcome_t;

    bit         slot_used [BP_SLOTS];
    bit [23:0]  slot_key [BP_SLOTS];
    bit         pending;
    bit         paused;
    step_kind_t kind;
    bit [9:0]   armed_depth;
    bit [15:0]  armed_line;
    bit [9:0]   held_depth;
    bit [15:0]  held_line;
    bit         seen_valid;
    bit [41:0]  seen_loc;
    outcome_t   expected_outcomes[$];
    int         mismatches;

    function int find_slot(bit [23:0] key);
        for (int i = 0; i < BP_SLOTS; i++)
        begin
            if (slot_used[i] && slot_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    function void note_command(action_t act, bit [15:0] tok, bit [7:0] scr,
                               bit [15:0] ln, bit [9:0] dep);
        outcome_t  o;
        bit [23:0] key;
        bit [41:0] loc;
        bit        bp_hit;
        bit        step_hit;
        int        slot;
        o = '0;
        key = {scr, ln};
        loc = {tok, ln, dep};
        case (act)
            ACT_LINE:
            begin
                if (!paused && !(seen_valid && seen_loc == loc))
                begin
                    seen_valid = 1'b1;
                    seen_loc = loc;
                    bp_hit = find_slot(key) >= 0;
                    case (kind)
                        STEP_INTO: step_hit = dep != armed_depth || ln != armed_line;
                        STEP_OVER: step_hit = dep < armed_depth ||
                                              (dep == armed_depth && ln != armed_line);
                        STEP_OUT:  step_hit = dep < armed_depth;
                        default:   step_hit = 1'b0;
                    endcase
                    if (pending || bp_hit || step_hit)
                    begin
                        o.pnow = 1'b1;
                        o.reason = bp_hit ? REASON_BP :
                                   (pending ? REASON_REQUEST : REASON_STEP);
                        pending = 1'b0;
                        kind = STEP_NONE;
                        paused = 1'b1;
                        held_depth = dep;
                        held_line = ln;
                    end
                end
            end
            ACT_ADD:
            begin
                if (find_slot(key) < 0)
                begin
                    o.full = 1'b1;
                    for (int i = 0; i < BP_SLOTS; i++)
                    begin
                        if (!slot_used[i])
                        begin
                            slot_used[i] = 1'b1;
                            slot_key[i] = key;
                            o.full = 1'b0;
                            break;
                        end
                    end
                end
            end
            ACT_REMOVE:
            begin
                slot = find_slot(key);
                if (slot >= 0)
                    slot_used[slot] = 1'b0;
            end
            ACT_REQUEST:
                pending = 1'b1;
            ACT_RESUME:
            begin
                kind = STEP_NONE;
                paused = 1'b0;
            end
            default:
            begin
                case (act)
                    ACT_STEP_INTO: kind = STEP_INTO;
                    ACT_STEP_OVER: kind = STEP_OVER;
                    default:       kind = STEP_OUT;
                endcase
                armed_depth = held_depth;
                armed_line = held_line;
                paused = 1'b0;
            end
        endcase
        o.paused = paused;
        expected_outcomes = {expected_outcomes, o};
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(logic pn, logic [1:0] rs, logic ip, logic tf);
        outcome_t o;
        if (expected_outcomes.size() == 0)
        begin
            report_mismatch("result strobe with no transaction outstanding");
            return;
        end
        o = expected_outcomes.pop_front();
        if (pn !== o.pnow)
            report_mismatch($sformatf("pause_now %b, expected %b", pn, o.pnow));
        if (rs !== o.reason)
            report_mismatch($sformatf("pause_reason %b, expected %b", rs, o.reason));
        if (ip !== o.paused)
            report_mismatch($sformatf("is_paused %b, expected %b", ip, o.paused));
        if (tf !== o.full)
            report_mismatch($sformatf("table_full %b, expected %b", tf, o.full));
    endtask

    task flag_leftovers();
        while (expected_outcomes.size() != 0)
        begin
            void'(expected_outcomes.pop_front());
            report_mismatch("transaction never produced a result");
        end
    endtask
endclass

module debug_break_and_step_trigger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1820;
    localparam int IDLE_LIMIT   = 200;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  action;
    logic [15:0] code_token;
    logic [7:0]  script_id;
    logic [15:0] line_number;
    logic [9:0]  call_depth;
    logic        done;
    logic        pause_now;
    logic [1:0]  pause_reason;
    logic        is_paused;
    logic        table_full;

    pause_predictor sb;
    bit             burst;
    int             idle_cycles;

    debug_break_and_step_trigger DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .code_token   (code_token),
        .script_id    (script_id),
        .line_number  (line_number),
        .call_depth   (call_depth),
        .done         (done),
        .pause_now    (pause_now),
        .pause_reason (pause_reason),
        .is_paused    (is_paused),
        .table_full   (table_full)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(pause_now, pause_reason, is_paused, table_full);
            if (done || (start && !busy))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    task automatic send(action_t act, logic [15:0] tok, logic [7:0] scr,
                        logic [15:0] ln, logic [9:0] dep);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        code_token  <= tok;
        script_id   <= scr;
        line_number <= ln;
        call_depth  <= dep;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(act, tok, scr, ln, dep);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_item(output bit counted);
        action_t     act;
        int          roll;
        int          d;
        logic [15:0] tok;
        logic [15:0] ln;
        logic [7:0]  scr;
        logic [9:0]  dep;
        roll = $urandom_range(0, 99);
        tok = 16'($urandom);
        scr = 8'($urandom);
        ln  = 16'($urandom);
        dep = 10'($urandom);
        if (sb.paused)
            act = roll < 25 ? ACT_RESUME : roll < 40 ? ACT_STEP_INTO :
                  roll < 55 ? ACT_STEP_OVER : roll < 70 ? ACT_STEP_OUT :
                  roll < 77 ? ACT_REQUEST : roll < 86 ? ACT_ADD :
                  roll < 93 ? ACT_REMOVE : ACT_LINE;
        else
            act = roll < 58 ? ACT_LINE : roll < 70 ? ACT_ADD :
                  roll < 78 ? ACT_REMOVE : roll < 83 ? ACT_REQUEST :
                  roll < 86 ? ACT_RESUME : roll < 90 ? ACT_STEP_INTO :
                  roll < 95 ? ACT_STEP_OVER : ACT_STEP_OUT;
        if (act == ACT_LINE)
        begin
            if ($urandom_range(0, 9) == 0)
                {tok, ln, dep} = sb.seen_loc;
            else
            begin
                if ($urandom_range(0, 7) != 0)
                    tok = 16'($urandom_range(0, 3));
                if ($urandom_range(0, 2) == 0)
                    ln = sb.held_line;
                else if ($urandom_range(0, 7) != 0)
                    ln = 16'($urandom_range(0, 7));
                if ($urandom_range(0, 7) != 0)
                begin
                    d = int'(sb.held_depth) + int'($urandom_range(0, 4)) - 2;
                    d = d < 0 ? 0 : (d > 1023 ? 1023 : d);
                    dep = 10'(d);
                end
            end
            if ($urandom_range(0, 7) != 0)
                scr = 8'($urandom_range(0, 3));
        end
        else if (act == ACT_ADD || act == ACT_REMOVE)
        begin
            if ($urandom_range(0, 7) != 0)
                scr = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 7) != 0)
                ln = 16'($urandom_range(0, 7));
        end
        counted = !(act == ACT_LINE && sb.paused);
        send(act, tok, scr, ln, dep);
    endtask

    initial
    begin
        int  accepted;
        int  iter;
        bit  counted;
        bit  drained;
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_LINE;
        code_token  = '0;
        script_id   = '0;
        line_number = '0;
        call_depth  = '0;
        idle_cycles = 0;
        burst       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send(ACT_LINE,      16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_ADD,       16'h0000, 8'hFF, 16'hFFFF, 10'h000);
        send(ACT_LINE,      16'hFFFF, 8'hFF, 16'hFFFF, 10'h3FF);
        send(ACT_LINE,      16'h0001, 8'hFF, 16'hFFFF, 10'h000);
        send(ACT_REQUEST,   16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_STEP_INTO, 16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_LINE,      16'hFFFF, 8'h00, 16'hFFFF, 10'h3FF);
        send(ACT_LINE,      16'h0001, 8'h00, 16'hFFFF, 10'h3FF);
        send(ACT_STEP_OVER, 16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_LINE,      16'h0002, 8'h00, 16'hFFFF, 10'h3FF);
        send(ACT_LINE,      16'h0002, 8'h00, 16'h0005, 10'h3FF);
        send(ACT_STEP_OUT,  16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_LINE,      16'h0003, 8'h00, 16'h0007, 10'h3FF);
        send(ACT_LINE,      16'h0003, 8'h00, 16'h0007, 10'h3FE);
        send(ACT_STEP_INTO, 16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_LINE,      16'h0004, 8'h00, 16'h0007, 10'h3FF);
        send(ACT_RESUME,    16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_RESUME,    16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_STEP_OVER, 16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_REMOVE,    16'h0000, 8'h01, 16'h0001, 10'h000);
        send(ACT_REMOVE,    16'h0000, 8'hFF, 16'hFFFF, 10'h000);
        for (int i = 0; i <= BP_SLOTS; i++)
            send(ACT_ADD, 16'h0000, 8'(i % 4), 16'(i / 4), 10'h000);
        send(ACT_ADD,       16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_REQUEST,   16'h0000, 8'h00, 16'h0000, 10'h000);
        send(ACT_LINE,      16'h0009, 8'h00, 16'h0000, 10'h005);
        send(ACT_RESUME,    16'h0000, 8'h00, 16'h0000, 10'h000);
        drain_results();

        accepted = 0;
        iter = 0;
        drained = 1'b0;
        while (accepted < RANDOM_ITEMS)
        begin
            if (iter % 50 == 0)
                burst = $urandom_range(0, 2) == 0;
            random_item(counted);
            if (counted)
                accepted++;
            iter++;
            if (!drained && accepted >= RANDOM_ITEMS / 2)
            begin
                drained = 1'b1;
                drain_results();
            end
        end
        drain_results();
        repeat (4) @(posedge clk);

        sb.flag_leftovers();
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/dbst_pkg.sv
rtl/dbst_bp_table.sv
rtl/debug_break_and_step_trigger.sv
rtl/dbst_checker.sv
dv/debug_break_and_step_trigger_tb.sv
